// File: rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types, widths and constants of the column pair occupancy scorer.
// ----------------------------------------------------------------------------
package cps_pkg;

   // column height and weight store geometry
   localparam int MAX_HEIGHT  = 64;
   localparam int LEVEL_W     = 6;
   localparam int TABLE_DEPTH = (MAX_HEIGHT < (1 << LEVEL_W)) ? MAX_HEIGHT : (1 << LEVEL_W);
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // field widths
   localparam int PROB_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int SUM_W    = 23;
   localparam int SCORE_W  = 16;
   localparam int ROW_W    = 3 * WEIGHT_W;

   // probability thresholds in Q0.16
   localparam logic [PROB_W-1:0] HALF_PROB = 16'd32768;
   localparam logic [PROB_W-1:0] OCC_LIMIT = 16'd39322;

   // score of an empty column, round of 256 * ln 0.5
   localparam logic signed [SCORE_W-1:0] LOG_HALF  = -16'sd177;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = -16'sd32768;

   // ln(1 + exp(-t)) in Q8.8 at steps of 0.25
   localparam int SOFTPLUS_N   = 27;
   localparam int SOFTPLUS_END = SOFTPLUS_N - 1;
   localparam logic [7:0] SOFTPLUS_TAB [SOFTPLUS_N] = '{
      8'd177, 8'd147, 8'd121, 8'd99, 8'd80, 8'd64, 8'd52, 8'd41, 8'd32, 8'd26,
      8'd20, 8'd16, 8'd12, 8'd10, 8'd8, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2,
      8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0
   };

   // command codes carried in tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PAIR = 1'b1;

   // voxel class
   typedef enum logic [1:0] {
      CLS_UNKNOWN = 2'd0,
      CLS_FREE    = 2'd1,
      CLS_OCC     = 2'd2
   } cls_type;

   // control of one voxel pair on its way to the accumulator
   typedef struct packed {
      logic    valid;
      logic    last;
      logic    lvl_ok;
      logic    hit_occ;
      cls_type cls_x;
      cls_type cls_y;
   } pair_ctl_type;

   // finished column sum handed to the log-sigmoid stage
   typedef struct packed {
      logic                    valid;
      logic                    seen;
      logic signed [SUM_W-1:0] sum;
   } col_res_type;

   function automatic cls_type classify(input logic [PROB_W-1:0] p);
      cls_type c;
      if (p < HALF_PROB) c = CLS_FREE;
      else if (p > HALF_PROB) c = CLS_OCC;
      else c = CLS_UNKNOWN;
      return c;
   endfunction

endpackage

// File: rtl/cps_weight_ram.sv
// ----------------------------------------------------------------------------
// cps_weight_ram
// Per-level weight store, one row of three weights, registered read.
// ----------------------------------------------------------------------------
module cps_weight_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [cps_pkg::ADDR_W-1:0] wr_addr,
   input  logic [cps_pkg::ROW_W-1:0]  wr_data,
   input  logic                      rd_en,
   input  logic [cps_pkg::ADDR_W-1:0] rd_addr,
   output logic [cps_pkg::ROW_W-1:0]  rd_data
);
   import cps_pkg::*;

   logic [ROW_W-1:0] mem [TABLE_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while not read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/cps_accum.sv
// ----------------------------------------------------------------------------
// cps_accum
// Weight select and saturating column sum, one voxel pair per cycle while advance is high.
// ----------------------------------------------------------------------------
module cps_accum (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  cps_pkg::pair_ctl_type              in_ctl,
   input  logic [cps_pkg::ROW_W-1:0]           row_data,
   input  logic signed [cps_pkg::WEIGHT_W-1:0] bias,
   output cps_pkg::col_res_type               col_res
);
   import cps_pkg::*;

   pair_ctl_type            ctl_ff;
   logic                    open_ff, open_in;
   logic                    seen_ff, seen_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   col_res_type             res_ff, res_in;

   logic signed [WEIGHT_W-1:0] w_free, w_occ, w_dis, w_sel;
   logic signed [SUM_W-1:0]    sum_base;
   logic signed [SUM_W:0]      sum_wide;

   assign w_free = row_data[WEIGHT_W-1:0];
   assign w_occ  = row_data[2*WEIGHT_W-1:WEIGHT_W];
   assign w_dis  = row_data[3*WEIGHT_W-1:2*WEIGHT_W];

   // weight for the pair of classes
   always_comb begin
      w_sel = '0;
      if (ctl_ff.lvl_ok) begin
         if (ctl_ff.cls_x == CLS_FREE && ctl_ff.cls_y == CLS_FREE) w_sel = w_free;
         else if (ctl_ff.cls_x == CLS_OCC && ctl_ff.cls_y == CLS_OCC) w_sel = w_occ;
         else if (ctl_ff.cls_x != CLS_UNKNOWN && ctl_ff.cls_y != CLS_UNKNOWN) w_sel = w_dis;
      end
   end

   // add with saturation, a new column starts from the bias
   always_comb begin
      sum_base = open_ff ? sum_ff : SUM_W'(bias);
      sum_wide = (SUM_W + 1)'(sum_base) + (SUM_W + 1)'(w_sel);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
      seen_in = (open_ff & seen_ff) | (ctl_ff.lvl_ok & ctl_ff.hit_occ);
      open_in = ~ctl_ff.last;
   end

   // finished column goes out on the last pair
   always_comb begin
      res_in.valid = ctl_ff.valid & ctl_ff.last;
      res_in.seen  = seen_in;
      res_in.sum   = sum_in;
   end

   // pair stage and column state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
         open_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         res_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff <= in_ctl;
         res_ff <= res_in;
         if (ctl_ff.valid) begin
            open_ff <= open_in;
            seen_ff <= seen_in;
            sum_ff  <= sum_in;
         end
      end
   end

   assign col_res = res_ff;

`ifndef SYNTH
   // a finished column is never dropped while the output is blocked
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      !advance && res_ff.valid |=> res_ff.valid && $stable(res_ff.sum))
      else $error("column result lost during stall");
`endif

endmodule

// File: rtl/cps_logsig.sv
// ----------------------------------------------------------------------------
// cps_logsig
// Log-sigmoid of the column sum by table and interpolation, output register.
// ----------------------------------------------------------------------------
module cps_logsig (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  cps_pkg::col_res_type              col_res,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic signed [cps_pkg::SCORE_W-1:0] out_score,
   output logic                              out_empty
);
   import cps_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic                      empty_ff;

   logic [SUM_W-1:0]   mag;
   logic               beyond;
   logic [4:0]         idx;
   logic [5:0]         frac;
   logic [7:0]         ta, tb, diff;
   logic [14:0]        prod;
   logic [7:0]         corr, g;
   logic signed [SUM_W:0] r;

   // softplus of the magnitude, zero past the table end
   always_comb begin
      mag    = col_res.sum[SUM_W-1] ? SUM_W'(-col_res.sum) : SUM_W'(col_res.sum);
      beyond = mag[SUM_W-1:6] >= (SUM_W - 6)'(SOFTPLUS_END);
      idx    = beyond ? 5'd0 : mag[10:6];
      frac   = mag[5:0];
      ta     = SOFTPLUS_TAB[idx];
      tb     = SOFTPLUS_TAB[5'(idx + 5'd1)];
      diff   = ta - tb;
      prod   = 15'(diff) * 15'(frac) + 15'd32;
      corr   = prod[13:6];
      g      = beyond ? 8'd0 : 8'(ta - corr);
   end

   // log-sigmoid with saturation, empty column gives log one half
   always_comb begin
      if (col_res.sum[SUM_W-1]) r = (SUM_W + 1)'(col_res.sum) - (SUM_W + 1)'(g);
      else r = -(SUM_W + 1)'(g);
      if (!col_res.seen) score_in = LOG_HALF;
      else if (r < (SUM_W + 1)'(SCORE_MIN)) score_in = SCORE_MIN;
      else score_in = r[SCORE_W-1:0];
      valid_in = (advance && col_res.valid) ? 1'b1 : (valid_ff && !out_ready);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && col_res.valid) begin
         score_ff <= score_in;
         empty_ff <= ~col_res.seen;
      end
   end

   assign out_valid = valid_ff;
   assign out_score = score_ff;
   assign out_empty = empty_ff;

endmodule

// File: rtl/column_pair_occupancy_scorer_core.sv
// ----------------------------------------------------------------------------
// column_pair_occupancy_scorer_core
// Scores the likeness of two occupancy columns from per-level weights.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields, low bit up                      | tuser | tlast
//  req_    | in  | level, prob_x, prob_y, y_in_grid, weight_both_ | cmd   | last_pair
//          |     | free, weight_both_occupied, weight_disagree    |       |
//  rsp_    | out | log_score, column_empty                        | -     | -
//  csr_    | in  | score_bias, written when csr_wen is high       | -     | -
//
//  one beat per cycle on req_ while req_tready is high; loads and pairs mix freely
//  after the last pair is accepted, its result goes through the weight memory read,
//  then the sum stage, then the log-sigmoid register
//  reset is synchronous; the weight memory is not cleared
//  req_tready drops only when a second result would meet a blocked rsp_
// ----------------------------------------------------------------------------
module column_pair_occupancy_scorer_core (
   input  logic        clock,
   input  logic        reset,
   // level[5:0], prob_x[21:6], prob_y[37:22], y_in_grid[38],
   // weight_both_free[54:39], weight_both_occupied[70:55], weight_disagree[86:71]
   input  logic [87:0] req_tdata,
   input  logic        req_tuser,   // cmd[0]
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // log_score[15:0], column_empty[16]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);
   import cps_pkg::*;

   logic signed [WEIGHT_W-1:0] bias_ff;
   logic                       advance;
   logic                       accept;
   logic [LEVEL_W-1:0]         level;
   logic [PROB_W-1:0]          prob_x, prob_y;
   logic                       y_in_grid;
   logic                       lvl_ok;
   pair_ctl_type               in_ctl;
   logic [ROW_W-1:0]           row_data;
   col_res_type                col_res;
   logic signed [SCORE_W-1:0]  score;
   logic                       empty;

   // field unpack
   assign level     = req_tdata[5:0];
   assign prob_x    = req_tdata[21:6];
   assign prob_y    = req_tdata[37:22];
   assign y_in_grid = req_tdata[38];
   assign lvl_ok    = int'(level) < MAX_HEIGHT;

   // stall only when a finished column meets a blocked output
   assign advance    = !(col_res.valid && rsp_tvalid && !rsp_tready);
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   // bias register
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else if (csr_wen) begin
         bias_ff <= csr_wdata;
      end
   end

   // pair control for the sum stage
   always_comb begin
      in_ctl.valid   = accept && (req_tuser == CMD_PAIR);
      in_ctl.last    = req_tlast;
      in_ctl.lvl_ok  = lvl_ok;
      in_ctl.hit_occ = prob_x >= OCC_LIMIT;
      in_ctl.cls_x   = classify(prob_x);
      in_ctl.cls_y   = y_in_grid ? classify(prob_y) : CLS_UNKNOWN;
   end

   cps_weight_ram u_ram (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == CMD_LOAD) && lvl_ok),
      .wr_addr (level[ADDR_W-1:0]),
      .wr_data (req_tdata[86:39]),
      .rd_en   (accept && (req_tuser == CMD_PAIR)),
      .rd_addr (level[ADDR_W-1:0]),
      .rd_data (row_data)
   );

   cps_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (in_ctl),
      .row_data (row_data),
      .bias     (bias_ff),
      .col_res  (col_res)
   );

   cps_logsig u_logsig (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .col_res   (col_res),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_score (score),
      .out_empty (empty)
   );

   assign rsp_tdata = {7'd0, empty, score};

`ifndef SYNTH
   // input is held back only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && col_res.valid)
      else $error("input stalled without a waiting result");

   // an empty column always scores log one half
   a_empty_score: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[15:0] == LOG_HALF)
      else $error("empty column with wrong score");

   // a log of a probability is never positive
   a_score_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15] || rsp_tdata[15:0] == 16'd0)
      else $error("positive log score");
`endif

endmodule

// File: tb/sv/tb_column_pair_occupancy_scorer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_pair_occupancy_scorer_core
// Streams weight loads and voxel pairs into the column scorer, predicts each
// column's log-sigmoid score and empty flag, and checks the result beats in
// order. Covers four idle/stall mixes and several bias settings.
// ----------------------------------------------------------------------------
module tb_column_pair_occupancy_scorer_core;
   import cps_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SUM_HI        = 4194303;
   localparam int SUM_LO        = -4194304;
   localparam int SP_TAB [27]   = '{
      177, 147, 121, 99, 80, 64, 52, 41, 32, 26, 20, 16, 12, 10,
      8, 6, 5, 4, 3, 2, 2, 1, 1, 1, 1, 0, 0
   };

   typedef enum int {ENT_BEAT, ENT_CFG, ENT_DRAIN, ENT_MODE} entry_kind_type;

   typedef struct {
      entry_kind_type             kind;
      logic                       cmd;
      logic [LEVEL_W-1:0]         level;
      logic [PROB_W-1:0]          prob_x;
      logic [PROB_W-1:0]          prob_y;
      logic                       y_in_grid;
      logic signed [WEIGHT_W-1:0] w_free;
      logic signed [WEIGHT_W-1:0] w_occ;
      logic signed [WEIGHT_W-1:0] w_dis;
      logic                       last_pair;
      logic signed [15:0]         bias;
      int                         send_idle;
      int                         recv_stall;
   } req_entry_type;

   typedef struct {
      logic signed [SCORE_W-1:0] log_score;
      logic                      column_empty;
   } col_score_type;

   // dut signals, all inputs known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [87:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_wen = 1'b0;
   logic [15:0] csr_wdata = '0;

   // stimulus and prediction state
   req_entry_type pending_beats [$];
   col_score_type expected_scores [$];
   req_entry_type cur_beat;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           settle_cnt = 0;
   int           n_errors = 0;
   int           n_beats = 0;
   int           cycle_cnt = 0;

   logic signed [WEIGHT_W-1:0] free_w [MAX_HEIGHT];
   logic signed [WEIGHT_W-1:0] occ_w  [MAX_HEIGHT];
   logic signed [WEIGHT_W-1:0] dis_w  [MAX_HEIGHT];
   logic signed [SUM_W-1:0]    col_sum = '0;
   logic                       col_seen = 1'b0;
   logic                       col_open = 1'b0;
   logic signed [15:0]         bias_q = '0;

   column_pair_occupancy_scorer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic cls_type voxel_class(input logic [PROB_W-1:0] p);
      if (p < HALF_PROB) return CLS_FREE;
      if (p > HALF_PROB) return CLS_OCC;
      return CLS_UNKNOWN;
   endfunction

   // ln(1 + exp(-t)) in Q8.8 for t >= 0
   function automatic int softplus_at(input int t);
      int i;
      int f;
      i = t >>> 6;
      f = t & 63;
      if (i >= 26) return 0;
      return SP_TAB[i] - (((SP_TAB[i] - SP_TAB[i+1]) * f + 32) >>> 6);
   endfunction

   function automatic logic signed [SCORE_W-1:0] log_sigmoid_q88(input int s);
      int r;
      if (s >= 0) r = -softplus_at(s);
      else r = s - softplus_at(-s);
      if (r < -32768) r = -32768;
      return r[SCORE_W-1:0];
   endfunction

   // update the column model with one accepted beat
   task automatic score_beat(input req_entry_type b);
      cls_type                    cx;
      cls_type                    cy;
      logic signed [WEIGHT_W-1:0] w;
      int                         acc;
      col_score_type              res;
      if (b.cmd == CMD_LOAD) begin
         free_w[b.level] = b.w_free;
         occ_w[b.level]  = b.w_occ;
         dis_w[b.level]  = b.w_dis;
      end else begin
         if (!col_open) begin
            col_sum  = SUM_W'(bias_q);
            col_seen = 1'b0;
            col_open = 1'b1;
         end
         cx = voxel_class(b.prob_x);
         cy = b.y_in_grid ? voxel_class(b.prob_y) : CLS_UNKNOWN;
         w  = '0;
         if (cx == CLS_FREE && cy == CLS_FREE) w = free_w[b.level];
         else if (cx == CLS_OCC && cy == CLS_OCC) w = occ_w[b.level];
         else if (cx != CLS_UNKNOWN && cy != CLS_UNKNOWN) w = dis_w[b.level];
         acc = int'(col_sum) + int'(w);
         if (acc > SUM_HI) acc = SUM_HI;
         if (acc < SUM_LO) acc = SUM_LO;
         col_sum = acc[SUM_W-1:0];
         if (b.prob_x >= OCC_LIMIT) col_seen = 1'b1;
         if (b.last_pair) begin
            res.log_score    = col_seen ? log_sigmoid_q88(int'(col_sum)) : LOG_HALF;
            res.column_empty = !col_seen;
            expected_scores.push_back(res);
            col_sum  = SUM_W'(bias_q);
            col_seen = 1'b0;
            col_open = 1'b0;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: one queue entry per cycle while no beat is waiting, valid held until the beat is taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      req_entry_type nxt;
      logic       busy;
      logic       nv;
      logic       nwen;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_wen    <= 1'b0;
      end else begin
         busy = req_tvalid;
         nv   = req_tvalid;
         nwen = 1'b0;
         if (req_tvalid && req_tready) begin
            score_beat(cur_beat);
            busy       = 1'b0;
            nv         = 1'b0;
            settle_cnt = 0;
         end else if (settle_cnt < 1000) begin
            settle_cnt++;
         end
         if (!busy && pending_beats.size() > 0) begin
            nxt = pending_beats[0];
            case (nxt.kind)
               ENT_BEAT: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     void'(pending_beats.pop_front());
                     cur_beat  = nxt;
                     nv        = 1'b1;
                     req_tdata <= {1'b0, nxt.w_dis, nxt.w_occ, nxt.w_free, nxt.y_in_grid,
                                   nxt.prob_y, nxt.prob_x, nxt.level};
                     req_tuser <= nxt.cmd;
                     req_tlast <= nxt.last_pair;
                  end
               end
               ENT_CFG: begin
                  // block idle: nothing owed and the pipe has run dry
                  if (expected_scores.size() == 0 && settle_cnt >= SETTLE_CYCLES) begin
                     void'(pending_beats.pop_front());
                     nwen      = 1'b1;
                     csr_wdata <= nxt.bias;
                     bias_q    = nxt.bias;
                  end
               end
               ENT_DRAIN: begin
                  if (expected_scores.size() == 0) void'(pending_beats.pop_front());
               end
               default: begin
                  void'(pending_beats.pop_front());
                  send_idle_pct  = nxt.send_idle;
                  recv_stall_pct = nxt.recv_stall;
               end
            endcase
         end
         req_tvalid <= nv;
         csr_wen    <= nwen;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: random backpressure, in-order compare of result beats
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      col_score_type exp_s;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_scores.size() == 0) begin
               $display("%0t: unexpected result beat, tdata %h", $time, rsp_tdata);
               n_errors++;
            end else begin
               exp_s = expected_scores.pop_front();
               if ($signed(rsp_tdata[15:0]) !== exp_s.log_score) begin
                  $display("%0t: log_score expected %0d actual %0d", $time,
                           exp_s.log_score, $signed(rsp_tdata[15:0]));
                  n_errors++;
               end
               if (rsp_tdata[16] !== exp_s.column_empty) begin
                  $display("%0t: column_empty expected %0b actual %0b", $time,
                           exp_s.column_empty, rsp_tdata[16]);
                  n_errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_load(input int lvl, input int wf, input int wo, input int wd,
                            input bit lst);
      req_entry_type e;
      e           = '{kind: ENT_BEAT, default: '0};
      e.cmd       = CMD_LOAD;
      e.level     = lvl[LEVEL_W-1:0];
      e.prob_x    = 16'($urandom);
      e.prob_y    = 16'($urandom);
      e.y_in_grid = 1'($urandom_range(1));
      e.w_free    = wf[15:0];
      e.w_occ     = wo[15:0];
      e.w_dis     = wd[15:0];
      e.last_pair = lst;
      pending_beats.push_back(e);
      n_beats++;
   endtask

   task automatic push_pair(input int lvl, input int px, input int py, input bit yin,
                            input bit lst);
      req_entry_type e;
      e           = '{kind: ENT_BEAT, default: '0};
      e.cmd       = CMD_PAIR;
      e.level     = lvl[LEVEL_W-1:0];
      e.prob_x    = px[15:0];
      e.prob_y    = py[15:0];
      e.y_in_grid = yin;
      e.w_free    = 16'($urandom);
      e.w_occ     = 16'($urandom);
      e.w_dis     = 16'($urandom);
      e.last_pair = lst;
      pending_beats.push_back(e);
      n_beats++;
   endtask

   task automatic push_ctl(input entry_kind_type k, input int bias, input int s_pct,
                           input int r_pct);
      req_entry_type e;
      e            = '{kind: k, default: '0};
      e.bias       = bias[15:0];
      e.send_idle  = s_pct;
      e.recv_stall = r_pct;
      pending_beats.push_back(e);
   endtask

   // threshold corners now and then, otherwise anything
   function automatic int pick_prob();
      int corners [7] = '{0, 65535, 32767, 32768, 32769, 39321, 39322};
      if ($urandom_range(3) == 0) return corners[$urandom_range(6)];
      return $urandom_range(65535);
   endfunction

   // a column of random pairs with the odd weight reload mixed in
   task automatic push_column(input int npairs, input bit empty_col);
      int px;
      for (int k = 0; k < npairs; k++) begin
         if ($urandom_range(9) == 0)
            push_load($urandom_range(63), $urandom, $urandom, $urandom,
                      1'($urandom_range(1)));
         px = pick_prob();
         if (empty_col && px >= OCC_LIMIT) px = $urandom_range(39321);
         push_pair($urandom_range(63), px, pick_prob(), $urandom_range(7) != 0,
                   k == npairs - 1);
      end
   endtask

   // one level with a huge weight, then enough pairs to hit the sum rail
   task automatic push_rail_column(input int w);
      int lvl;
      int npairs;
      lvl    = $urandom_range(63);
      npairs = $urandom_range(135, 150);
      push_load(lvl, w, w, w, 1'($urandom_range(1)));
      for (int k = 0; k < npairs; k++)
         push_pair(lvl, (k == 0) ? 65535 : $urandom_range(32769, 65535),
                   ($urandom_range(1) != 0) ? $urandom_range(32769, 65535)
                                            : $urandom_range(32767),
                   1'b1, k == npairs - 1);
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin : run_test
      int phase_s [4] = '{0, 72, 0, 30};
      int phase_r [4] = '{0, 0, 72, 30};
      int phase_b [4] = '{32767, -32768, 0, 0};
      int start_cnt;
      bit drained;

      // directed: weight extremes, class corners, empty and saturated columns
      push_load(0, 32767, -32768, 1, 1'b0);
      push_load(63, -32768, 32767, -1, 1'b1);   // tlast on a load is ignored
      push_load(1, 256, -256, 512, 1'b0);
      push_pair(0, 0, 0, 1'b1, 1'b0);
      push_pair(63, 65535, 65535, 1'b1, 1'b1);
      push_pair(0, 32768, 0, 1'b1, 1'b1);       // unknown x, empty column
      push_pair(1, 39322, 32767, 1'b1, 1'b1);   // just at the occupied limit
      push_pair(1, 39321, 40000, 1'b1, 1'b0);
      push_pair(0, 65535, 30000, 1'b0, 1'b0);   // y off grid adds nothing
      push_pair(1, 32769, 32769, 1'b1, 1'b1);
      push_pair(0, 65535, 65535, 1'b1, 1'b0);
      push_pair(0, 65535, 65535, 1'b1, 1'b1);   // deep negative, score rail
      push_pair(63, 0, 32768, 1'b1, 1'b0);
      push_pair(63, 32767, 65535, 1'b1, 1'b1);  // below 0.6 only, empty
      push_pair(63, 65535, 0, 1'b1, 1'b1);
      push_pair(1, 39321, 39321, 1'b1, 1'b1);   // just under the limit
      push_ctl(ENT_CFG, -32768, 0, 0);
      push_pair(1, 0, 0, 1'b1, 1'b1);
      push_pair(0, 65535, 0, 1'b0, 1'b1);
      push_ctl(ENT_CFG, 32767, 0, 0);
      push_pair(1, 65535, 0, 1'b1, 1'b1);
      push_pair(0, 40000, 65535, 1'b1, 1'b1);

      // fill every level before random pairs can touch it
      for (int l = 0; l < MAX_HEIGHT; l++)
         push_load(l, $urandom, $urandom, $urandom, 1'($urandom_range(1)));

      // random phases, each with its own idle mix and bias
      for (int ph = 0; ph < 4; ph++) begin
         push_ctl(ENT_MODE, 0, phase_s[ph], phase_r[ph]);
         push_ctl(ENT_CFG, (ph == 2) ? int'($urandom) : phase_b[ph], 0, 0);
         start_cnt = n_beats;
         drained   = 1'b0;
         while (n_beats - start_cnt < 100) begin
            if ($urandom_range(4) == 0) push_column($urandom_range(1, 6), 1'b1);
            else push_column($urandom_range(1, 10), 1'b0);
            if (!drained && n_beats - start_cnt > 50) begin
               if (ph == 0) push_ctl(ENT_MODE, 0, 0, 0);
               push_ctl(ENT_DRAIN, 0, 0, 0);
               drained = 1'b1;
            end
            if ($urandom_range(29) == 0) push_ctl(ENT_CFG, $urandom, 0, 0);
         end
         push_rail_column((ph % 2 == 0) ? 32767 : -32768);
      end

      // release reset, then wait for all work to finish
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_beats.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (n_errors == 0 && expected_scores.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
